FILE: src/sli_pkg.sv
// Shared types and codes of the sorted insertion list.
`timescale 1ns / 1ps
`default_nettype none
package sli_pkg;

  localparam int VALUE_W   = 32;
  localparam int POS_W     = 4;
  localparam int COUNT_W   = 5;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_INDEX = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_e;

  // Broadcast to every cell during the execute cycle.
  typedef struct packed {
    logic                      ins;
    logic                      rem;
    logic                      desc;
    logic signed [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: src/sorted_list_insert_find_remove.sv
// Top level of the sorted insertion list: handshakes, count and the row of cells.
//
//  channel  dir  fields
//  s_axis   in   tuser: operation; tdata: value, position
//  m_axis   out  tuser: status; tdata: result_value .. is_empty
//  cfg      in   order_descending, written when cfg_we_i is high
//
// An item is captured first; then, in its execute cycle, every cell compares
// against the broadcast value and shifts with its neighbor in parallel.
// The next item is accepted while a result waits in the output register; the
// execute cycle waits only until that register is free.
// Reset clears the count, the order and the handshake state; the entries
// themselves are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sorted_list_insert_find_remove #(
  parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // value[31:0], position[35:32], zero pad
  input  wire logic [1:0]  s_axis_tuser,  // operation[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // result_value[31:0], result_position[35:32], found[36], entry_count[41:37],
  // is_empty[42], zero pad
  output logic [47:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser,  // status[1:0]
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i
);
  import sli_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int XW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  fsm_e                state_q, state_d;
  op_e                 op_q;
  logic signed [VALUE_W-1:0] val_q;
  logic [POS_W-1:0]    pos_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                desc_q;

  logic                out_free;
  logic                exec;
  logic                full;
  logic                pos_ok;
  logic [XW-1:0]       pos_x, cnt_x, cnt_dx, find_x;
  cell_ctrl_t          ctrl;

  logic signed [VALUE_W-1:0] ent     [CAPACITY];
  logic                      holds   [CAPACITY];
  logic                      hit_any [CAPACITY];
  logic                      hit     [CAPACITY];
  logic [VALUE_W-1:0]        rd      [CAPACITY];
  logic [IDX_W-1:0]          find_idx;
  logic                      find_hit;

  logic                m_valid_q;
  logic [VALUE_W-1:0]  res_val_q,  res_val_d;
  logic [POS_W-1:0]    res_pos_q,  res_pos_d;
  logic                found_q,    found_d;
  status_e             status_q,   status_d;
  logic [COUNT_W-1:0]  res_cnt_q;
  logic                empty_q;

  // Handshake and sequencing.
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: if (s_axis_tvalid) state_d = FSM_EXEC;
      FSM_EXEC: if (out_free) state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    exec          = 1'b0;
    case (state_q)
      FSM_IDLE: s_axis_tready = 1'b1;
      FSM_EXEC: exec = out_free;
      default:  s_axis_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      desc_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) desc_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q  <= op_e'(s_axis_tuser);
      val_q <= s_axis_tdata[VALUE_W-1:0];
      pos_q <= s_axis_tdata[VALUE_W+POS_W-1:VALUE_W];
    end
  end

  // Index checks and the new count.
  assign pos_x  = XW'(pos_q);
  assign cnt_x  = XW'(cnt_q);
  assign full   = cnt_q == CNT_W'(CAPACITY);
  assign pos_ok = pos_x < cnt_x;

  assign ctrl.ins   = exec && (op_q == OP_INSERT) && !full;
  assign ctrl.rem   = exec && (op_q == OP_REMOVE) && pos_ok;
  assign ctrl.desc  = desc_q;
  assign ctrl.value = val_q;

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl.ins) cnt_d = cnt_q + 1'b1;
    else if (ctrl.rem) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else         cnt_q <= cnt_d;
  end

  // Row of cells; data and flags ripple from index 0 upward.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] l_val, r_val;
    logic                      l_holds, l_hit;
    logic [VALUE_W-1:0]        l_rd;
    if (i == 0) begin : g_first
      assign l_val   = val_q;
      assign l_holds = 1'b1;
      assign l_hit   = 1'b0;
      assign l_rd    = '0;
    end else begin : g_inner
      assign l_val   = ent[i-1];
      assign l_holds = holds[i-1];
      assign l_hit   = hit_any[i-1];
      assign l_rd    = rd[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign r_val = ent[i];
    end else begin : g_mid
      assign r_val = ent[i+1];
    end
    sli_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .pos_i        (pos_q),
      .cnt_i        (cnt_q),
      .left_val_i   (l_val),
      .left_holds_i (l_holds),
      .left_hit_i   (l_hit),
      .left_rd_i    (l_rd),
      .right_val_i  (r_val),
      .val_o        (ent[i]),
      .holds_o      (holds[i]),
      .hit_any_o    (hit_any[i]),
      .hit_o        (hit[i]),
      .rd_o         (rd[i])
    );
  end

  // The hit flags are one-hot, so the index is an OR of the set positions.
  always_comb begin
    find_idx = '0;
    find_hit = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit[i]) begin
        find_idx = find_idx | IDX_W'(i);
        find_hit = 1'b1;
      end
    end
  end

  assign find_x = XW'(find_idx);
  assign cnt_dx = XW'(cnt_d);

  always_comb begin
    res_val_d = '0;
    res_pos_d = '0;
    found_d   = 1'b0;
    status_d  = STAT_OK;
    case (op_q)
      OP_INSERT: begin
        if (full) status_d = STAT_FULL;
      end
      OP_FIND: begin
        if (find_hit) begin
          found_d   = 1'b1;
          res_pos_d = find_x[POS_W-1:0];
        end
      end
      OP_REMOVE: begin
        if (pos_ok) begin
          res_val_d = rd[CAPACITY-1];
          res_pos_d = pos_q;
          found_d   = (pos_x + 1'b1) < cnt_x;
        end else begin
          status_d = STAT_BAD_INDEX;
        end
      end
      OP_READ: begin
        if (pos_ok) res_val_d = rd[CAPACITY-1];
        else        status_d  = STAT_BAD_INDEX;
      end
      default: status_d = STAT_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (exec) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      res_val_q <= res_val_d;
      res_pos_q <= res_pos_d;
      found_q   <= found_d;
      status_q  <= status_d;
      res_cnt_q <= cnt_dx[COUNT_W-1:0];
      empty_q   <= cnt_d == '0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {5'd0, empty_q, res_cnt_q, found_q, res_pos_q, res_val_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> m_valid_q)
    else $error("execute cycle did not load a result");

  a_count_only_on_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exec |=> $stable(cnt_q))
    else $error("entry count changed outside an execute cycle");

  a_empty_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (empty_q == (res_cnt_q == '0)))
    else $error("empty flag disagrees with reported count");

endmodule
`default_nettype wire

FILE: src/sli_cell.sv
// One slot of the sorted list: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module sli_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire logic                               clk_i,
  input  wire sli_pkg::cell_ctrl_t                ctrl_i,
  input  wire logic [sli_pkg::POS_W-1:0]          pos_i,
  input  wire logic [CNT_W-1:0]                   cnt_i,
  input  wire logic signed [sli_pkg::VALUE_W-1:0] left_val_i,
  input  wire logic                               left_holds_i,
  input  wire logic                               left_hit_i,
  input  wire logic [sli_pkg::VALUE_W-1:0]        left_rd_i,
  input  wire logic signed [sli_pkg::VALUE_W-1:0] right_val_i,
  output logic signed [sli_pkg::VALUE_W-1:0]      val_o,
  output logic                                    holds_o,
  output logic                                    hit_any_o,
  output logic                                    hit_o,
  output logic [sli_pkg::VALUE_W-1:0]             rd_o
);
  import sli_pkg::*;

  logic signed [VALUE_W-1:0] entry_q, entry_d;
  logic                      occupied;
  logic                      rel;
  logic                      vrel;
  logic                      find_stop;
  logic                      match;
  logic                      sel;
  logic                      shift_left;

  // Both chains run from index 0 and stop at the first cell that ends the scan,
  // so the results hold only while the entries are sorted in the current order.
  assign occupied   = IDX < int'(cnt_i);
  assign rel        = ctrl_i.desc ? (entry_q >= ctrl_i.value) : (entry_q <= ctrl_i.value);
  assign vrel       = ctrl_i.desc ? (ctrl_i.value >= entry_q) : (ctrl_i.value <= entry_q);
  assign holds_o    = left_holds_i && occupied && rel;
  assign find_stop  = occupied && vrel;
  assign match      = occupied && (entry_q == ctrl_i.value);
  assign hit_o      = match && !left_hit_i;
  assign hit_any_o  = left_hit_i || find_stop;
  assign sel        = IDX == int'(pos_i);
  assign rd_o       = left_rd_i | (sel ? entry_q : '0);
  assign shift_left = (IDX >= int'(pos_i)) && ((IDX + 1) < int'(cnt_i));
  assign val_o      = entry_q;

  // On insert the first cell that is empty or whose entry follows the value takes it
  // (equal entries stay before it), and every cell after that takes its left neighbor's entry.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && !holds_o) begin
      entry_d = left_holds_i ? ctrl_i.value : left_val_i;
    end else if (ctrl_i.rem && shift_left) begin
      entry_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
`default_nettype wire
